// ----- design/bfi_pkg.sv -----
// shared types, constants and codes of the brainf interpreter core
`default_nettype none

package bfi_pkg;

  localparam int unsigned PROGRAM_DEPTH = 4096;
  localparam int unsigned TAPE_DEPTH    = 4096;
  localparam int unsigned NEST_DEPTH    = 256;

  localparam int unsigned PROG_AW = $clog2(PROGRAM_DEPTH);
  localparam int unsigned PC_W    = $clog2(PROGRAM_DEPTH + 1);
  localparam int unsigned TAPE_AW = $clog2(TAPE_DEPTH);
  localparam int unsigned NEST_AW = $clog2(NEST_DEPTH);
  localparam int unsigned NEST_CW = $clog2(NEST_DEPTH + 1);
  localparam int unsigned CELL_W  = 16;

  localparam logic [PC_W-1:0]    PROG_FULL = PC_W'(PROGRAM_DEPTH);
  localparam logic [NEST_CW-1:0] NEST_FULL = NEST_CW'(NEST_DEPTH);
  localparam logic [TAPE_AW-1:0] TAPE_LAST = TAPE_AW'(TAPE_DEPTH - 1);

  localparam logic [7:0] CH_OPEN  = 8'h5B; // [
  localparam logic [7:0] CH_CLOSE = 8'h5D; // ]
  localparam logic [7:0] CH_RIGHT = 8'h3E; // >
  localparam logic [7:0] CH_LEFT  = 8'h3C; // <
  localparam logic [7:0] CH_INC   = 8'h2B; // +
  localparam logic [7:0] CH_DEC   = 8'h2D; // -
  localparam logic [7:0] CH_OUT   = 8'h2E; // .
  localparam logic [7:0] CH_IN    = 8'h2C; // ,

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_STEPPED   = 3'd1,
    ST_OUTPUT    = 3'd2,
    ST_HALTED    = 3'd3,
    ST_UNMATCHED = 3'd4,
    ST_FULL      = 3'd5,
    ST_DEEP      = 3'd6
  } status_e;

  typedef struct packed {
    status_e    status;
    logic [7:0] out_byte;
    logic       input_taken;
  } res_t;

  typedef struct packed {
    logic               prog_we;
    logic [PROG_AW-1:0] prog_waddr;
    logic [7:0]         prog_wdata;
    logic [PROG_AW-1:0] rd_addr;
    logic               jt_we;
    logic [PROG_AW-1:0] jt_waddr;
    logic [PROG_AW-1:0] jt_wdata;
    logic               stk_we;
    logic [NEST_AW-1:0] stk_waddr;
    logic [PROG_AW-1:0] stk_wdata;
    logic [NEST_AW-1:0] stk_raddr;
  } code_req_t;

  typedef struct packed {
    logic [7:0]         prog_rdata;
    logic [PROG_AW-1:0] jt_rdata;
    logic [PROG_AW-1:0] stk_rdata;
  } code_rsp_t;

  typedef struct packed {
    logic               we;
    logic [TAPE_AW-1:0] waddr;
    logic [CELL_W-1:0]  wdata;
    logic [TAPE_AW-1:0] raddr;
    logic               clear;
  } tape_req_t;

  typedef struct packed {
    logic [CELL_W-1:0] rdata;
    logic              busy;
  } tape_rsp_t;

endpackage

`default_nettype wire

// ----- design/bfi_if.sv -----
// valid/ready channel interfaces for items in and results out
`default_nettype none

interface bfi_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] char_in;
  logic       in_eof;

  modport source (output valid, output operation, output char_in, output in_eof,
                  input ready);
  modport sink (input valid, input operation, input char_in, input in_eof,
                output ready);
endinterface

interface bfi_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] out_byte;
  logic       input_taken;

  modport source (output valid, output status, output out_byte, output input_taken,
                  input ready);
  modport sink (input valid, input status, input out_byte, input input_taken,
                output ready);
endinterface

`default_nettype wire

// ----- design/brainf_interpreter_core.sv -----
// top level of the brainf interpreter core: sequencer, registers, memories
//
// items arrive on in_i (operation, char_in, in_eof) and each gives exactly
// one result on out_o (status, out_byte, input_taken); a transfer happens
// when valid and ready are both high at a rising edge of clk_i.
// one item is worked on at a time, its state held in synchronous memories
// with a registered read:
//   load of a plain character, halted step, refused start: in S_IDLE alone
//   load of a ']' that closes a bracket: stack read, then S_POP and S_LINK
//     (two jump table writes through the single write port)
//   step: program, jump table and tape read, then cell write-back in S_EXEC
//   start: S_CLEAR, waiting out a one-cell-a-cycle zeroing sweep when the
//     tape was written since the last clear or reset
// a result goes to the output register, or to the pending slot if one waits.
// the output register and a pending slot let one more item be taken while
// a result waits; with both full, ready stays low until out_o drains.
// rst_ni (asynchronous, active low) empties the program, clears the
// bracket stack and stops the run; the first start after reset zeroes the tape.
`default_nettype none

module brainf_interpreter_core (
  input  wire       logic clk_i,
  input  wire       logic rst_ni,
  bfi_in_if.sink    in_i,
  bfi_out_if.source out_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_POP   = 5'b00010,
    S_LINK  = 5'b00100,
    S_EXEC  = 5'b01000,
    S_CLEAR = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [bfi_pkg::PC_W-1:0]    length_q, length_d;
  logic [bfi_pkg::PC_W-1:0]    pc_q, pc_d;
  logic [bfi_pkg::TAPE_AW-1:0] tp_q, tp_d;
  logic [bfi_pkg::NEST_CW-1:0] open_cnt_q, open_cnt_d;
  logic                        unmatched_q, unmatched_d;
  logic                        running_q, running_d;

  logic [bfi_pkg::PROG_AW-1:0] pos_q, pos_d;
  logic [bfi_pkg::PROG_AW-1:0] opener_q, opener_d;
  logic [7:0]                  byte_q, byte_d;
  logic                        eof_q, eof_d;

  bfi_pkg::code_req_t code_req;
  bfi_pkg::code_rsp_t code_rsp;
  bfi_pkg::tape_req_t tape_req;
  bfi_pkg::tape_rsp_t tape_rsp;

  bfi_pkg::res_t res;
  logic          res_valid;
  logic          pend_full;
  logic          accept;

  logic [bfi_pkg::NEST_CW-1:0] open_dec;
  logic [bfi_pkg::PC_W-1:0]    jump_next;
  logic [bfi_pkg::CELL_W-1:0]  cur_cell;

  assign in_i.ready = (state_q == S_IDLE) && !pend_full;
  assign accept     = in_i.valid && in_i.ready;
  assign open_dec   = open_cnt_q - 1'b1;
  assign cur_cell   = tape_rsp.rdata;
  assign jump_next  = bfi_pkg::PC_W'(code_rsp.jt_rdata) + 1'b1;

  always_comb begin
    state_d     = state_q;
    length_d    = length_q;
    pc_d        = pc_q;
    tp_d        = tp_q;
    open_cnt_d  = open_cnt_q;
    unmatched_d = unmatched_q;
    running_d   = running_q;
    pos_d       = pos_q;
    opener_d    = opener_q;
    byte_d      = byte_q;
    eof_d       = eof_q;

    code_req            = '0;
    code_req.rd_addr    = pc_q[bfi_pkg::PROG_AW-1:0];
    code_req.prog_waddr = length_q[bfi_pkg::PROG_AW-1:0];
    code_req.prog_wdata = in_i.char_in;
    code_req.stk_waddr  = open_cnt_q[bfi_pkg::NEST_AW-1:0];
    code_req.stk_wdata  = length_q[bfi_pkg::PROG_AW-1:0];
    code_req.stk_raddr  = open_dec[bfi_pkg::NEST_AW-1:0];

    tape_req       = '0;
    tape_req.raddr = tp_q;
    tape_req.waddr = tp_q;

    res       = '{status: bfi_pkg::ST_ACCEPTED, out_byte: 8'h00, input_taken: 1'b0};
    res_valid = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_i.operation)
            bfi_pkg::OP_LOAD: begin
              running_d = 1'b0;
              if (length_q == bfi_pkg::PROG_FULL) begin
                res.status = bfi_pkg::ST_FULL;
                res_valid  = 1'b1;
              end else begin
                code_req.prog_we = 1'b1;
                length_d         = length_q + 1'b1;
                res_valid        = 1'b1;
                if (in_i.char_in == bfi_pkg::CH_OPEN) begin
                  if (open_cnt_q == bfi_pkg::NEST_FULL) begin
                    unmatched_d = 1'b1;
                    res.status  = bfi_pkg::ST_DEEP;
                  end else begin
                    code_req.stk_we = 1'b1;
                    open_cnt_d      = open_cnt_q + 1'b1;
                  end
                end else if (in_i.char_in == bfi_pkg::CH_CLOSE) begin
                  if (open_cnt_q == '0) begin
                    unmatched_d = 1'b1;
                  end else begin
                    // stack top comes back next cycle
                    open_cnt_d = open_dec;
                    pos_d      = length_q[bfi_pkg::PROG_AW-1:0];
                    res_valid  = 1'b0;
                    state_d    = S_POP;
                  end
                end
              end
            end
            bfi_pkg::OP_START: begin
              if (unmatched_q || (open_cnt_q != '0)) begin
                running_d  = 1'b0;
                res.status = bfi_pkg::ST_UNMATCHED;
                res_valid  = 1'b1;
              end else begin
                tp_d           = '0;
                pc_d           = '0;
                running_d      = 1'b1;
                tape_req.clear = 1'b1;
                state_d        = S_CLEAR;
              end
            end
            bfi_pkg::OP_STEP: begin
              if (!running_q || (pc_q >= length_q)) begin
                running_d  = 1'b0;
                res.status = bfi_pkg::ST_HALTED;
                res_valid  = 1'b1;
              end else begin
                byte_d  = in_i.char_in;
                eof_d   = in_i.in_eof;
                state_d = S_EXEC;
              end
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        code_req.jt_we    = 1'b1;
        code_req.jt_waddr = code_rsp.stk_rdata;
        code_req.jt_wdata = pos_q;
        opener_d          = code_rsp.stk_rdata;
        state_d           = S_LINK;
      end
      S_LINK: begin
        code_req.jt_we    = 1'b1;
        code_req.jt_waddr = pos_q;
        code_req.jt_wdata = opener_q;
        res_valid         = 1'b1;
        state_d           = S_IDLE;
      end
      S_EXEC: begin
        res.status = bfi_pkg::ST_STEPPED;
        res_valid  = 1'b1;
        pc_d       = pc_q + 1'b1;
        state_d    = S_IDLE;
        case (code_rsp.prog_rdata)
          bfi_pkg::CH_RIGHT: begin
            tp_d = (tp_q == bfi_pkg::TAPE_LAST) ? '0 : tp_q + 1'b1;
          end
          bfi_pkg::CH_LEFT: begin
            tp_d = (tp_q == '0) ? bfi_pkg::TAPE_LAST : tp_q - 1'b1;
          end
          bfi_pkg::CH_INC: begin
            tape_req.we    = 1'b1;
            tape_req.wdata = cur_cell + 1'b1;
          end
          bfi_pkg::CH_DEC: begin
            tape_req.we    = 1'b1;
            tape_req.wdata = cur_cell - 1'b1;
          end
          bfi_pkg::CH_OUT: begin
            res.status   = bfi_pkg::ST_OUTPUT;
            res.out_byte = cur_cell[7:0];
          end
          bfi_pkg::CH_IN: begin
            tape_req.we = 1'b1;
            if (eof_q) begin
              tape_req.wdata = '1;
            end else begin
              tape_req.wdata  = bfi_pkg::CELL_W'(byte_q);
              res.input_taken = 1'b1;
            end
          end
          bfi_pkg::CH_OPEN: begin
            if (cur_cell == '0) begin
              pc_d = jump_next;
            end
          end
          bfi_pkg::CH_CLOSE: begin
            if (cur_cell != '0) begin
              pc_d = jump_next;
            end
          end
          default: begin
          end
        endcase
      end
      S_CLEAR: begin
        if (!tape_rsp.busy) begin
          res_valid = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      length_q    <= '0;
      pc_q        <= '0;
      tp_q        <= '0;
      open_cnt_q  <= '0;
      unmatched_q <= 1'b0;
      running_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      length_q    <= length_d;
      pc_q        <= pc_d;
      tp_q        <= tp_d;
      open_cnt_q  <= open_cnt_d;
      unmatched_q <= unmatched_d;
      running_q   <= running_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    opener_q <= opener_d;
    byte_q   <= byte_d;
    eof_q    <= eof_d;
  end

  bfi_code_store u_code (
    .clk_i (clk_i),
    .req_i (code_req),
    .rsp_o (code_rsp)
  );

  bfi_tape u_tape (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tape_req),
    .rsp_o  (tape_rsp)
  );

  bfi_result_q u_res (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .pend_full_o (pend_full),
    .out_o       (out_o)
  );

  // a finished result never lands on a full pending slot
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !pend_full)
    else $error("result produced while pending slot full");

  // a run only exists on a balanced program
  a_run_balanced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (!unmatched_q && (open_cnt_q == '0)))
    else $error("running with unbalanced brackets");

  // bracket stack and program never overrun their stores
  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (open_cnt_q <= bfi_pkg::NEST_FULL) && (length_q <= bfi_pkg::PROG_FULL))
    else $error("stack or program length out of range");

  // a step that is taken while running finishes in the cycle after it is taken, in S_EXEC
  a_step_two_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> res_valid ##1 (state_q == S_IDLE))
    else $error("step did not finish in its execute cycle");

endmodule

`default_nettype wire

// ----- design/bfi_code_store.sv -----
// program store, jump table and open-bracket stack memories
`default_nettype none

module bfi_code_store (
  input  wire                logic clk_i,
  input  bfi_pkg::code_req_t req_i,
  output bfi_pkg::code_rsp_t rsp_o
);

  logic [7:0]                  prog_mem [bfi_pkg::PROGRAM_DEPTH];
  logic [bfi_pkg::PROG_AW-1:0] jt_mem   [bfi_pkg::PROGRAM_DEPTH];
  logic [bfi_pkg::PROG_AW-1:0] stk_mem  [bfi_pkg::NEST_DEPTH];

  logic [7:0]                  prog_rdata_q;
  logic [bfi_pkg::PROG_AW-1:0] jt_rdata_q;
  logic [bfi_pkg::PROG_AW-1:0] stk_rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.prog_we) begin
      prog_mem[req_i.prog_waddr] <= req_i.prog_wdata;
    end
    prog_rdata_q <= prog_mem[req_i.rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.jt_we) begin
      jt_mem[req_i.jt_waddr] <= req_i.jt_wdata;
    end
    jt_rdata_q <= jt_mem[req_i.rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.stk_we) begin
      stk_mem[req_i.stk_waddr] <= req_i.stk_wdata;
    end
    stk_rdata_q <= stk_mem[req_i.stk_raddr];
  end

  assign rsp_o.prog_rdata = prog_rdata_q;
  assign rsp_o.jt_rdata   = jt_rdata_q;
  assign rsp_o.stk_rdata  = stk_rdata_q;

endmodule

`default_nettype wire

// ----- design/bfi_tape.sv -----
// tape memory with a zeroing sweep that runs only when the tape may hold nonzero cells
`default_nettype none

module bfi_tape (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  bfi_pkg::tape_req_t req_i,
  output bfi_pkg::tape_rsp_t rsp_o
);

  logic [bfi_pkg::CELL_W-1:0]  mem [bfi_pkg::TAPE_DEPTH];
  logic [bfi_pkg::CELL_W-1:0]  rdata_q;
  logic [bfi_pkg::TAPE_AW-1:0] clr_addr_q, clr_addr_d;
  logic                        busy_q, busy_d;
  logic                        dirty_q, dirty_d;

  logic                        wr_en;
  logic [bfi_pkg::TAPE_AW-1:0] wr_addr;
  logic [bfi_pkg::CELL_W-1:0]  wr_data;

  always_comb begin
    busy_d     = busy_q;
    dirty_d    = dirty_q;
    clr_addr_d = clr_addr_q;
    if (busy_q) begin
      if (clr_addr_q == bfi_pkg::TAPE_LAST) begin
        busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end else if (req_i.clear) begin
      // a clean tape already reads as zero
      if (dirty_q) begin
        busy_d     = 1'b1;
        clr_addr_d = '0;
        dirty_d    = 1'b0;
      end
    end else if (req_i.we) begin
      dirty_d = 1'b1;
    end
  end

  assign wr_en   = busy_q || req_i.we;
  assign wr_addr = busy_q ? clr_addr_q : req_i.waddr;
  assign wr_data = busy_q ? '0 : req_i.wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      // contents are unknown after reset, so the first start sweeps
      dirty_q    <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      busy_q     <= busy_d;
      dirty_q    <= dirty_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rsp_o.rdata = rdata_q;
  assign rsp_o.busy  = busy_q;

endmodule

`default_nettype wire

// ----- design/bfi_result_q.sv -----
// two-deep result buffer: output register plus one pending slot
`default_nettype none

module bfi_result_q (
  input  wire           logic clk_i,
  input  wire           logic rst_ni,
  input  wire           logic res_valid_i,
  input  bfi_pkg::res_t res_i,
  output logic          pend_full_o,
  bfi_out_if.source     out_o
);

  logic          out_valid_q, out_valid_d;
  logic          pend_valid_q, pend_valid_d;
  bfi_pkg::res_t out_q, out_d;
  bfi_pkg::res_t pend_q, pend_d;
  logic          out_free;

  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    if (out_free) begin
      if (pend_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = pend_q;
        pend_valid_d = res_valid_i;
        pend_d       = res_i;
      end else begin
        out_valid_d = res_valid_i;
        out_d       = res_i;
      end
    end else if (res_valid_i) begin
      pend_valid_d = 1'b1;
      pend_d       = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign pend_full_o       = pend_valid_q;
  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_q.status;
  assign out_o.out_byte    = out_q.out_byte;
  assign out_o.input_taken = out_q.input_taken;

endmodule

`default_nettype wire
